/* sv/ise_pkg.sv */
// ----------------------------------------------------------------------------
// Insertion sort engine package
// Beat types for both channels and the link between neighboring sort cells.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int unsigned DataWidth = 32;

  typedef struct packed {
    logic signed [DataWidth-1:0] sample_value;
    logic                        last_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] sorted_value;
    logic                        last_out;
  } out_beat_t;

  // What one cell shows to its neighbors: occupancy, whether it holds a value
  // greater than the one being inserted, and the held value.
  typedef struct packed {
    logic                        valid;
    logic                        gt;
    logic signed [DataWidth-1:0] value;
  } cell_link_t;

  // Seen by the first cell on its low side: occupied and never greater, so the
  // first greater cell takes the new value.
  localparam cell_link_t HeadLink = '{valid: 1'b1, gt: 1'b0, value: '0};
  // Seen by the last cell on its high side: empty, so draining vacates it.
  localparam cell_link_t TailLink = '{valid: 1'b0, gt: 1'b1, value: '0};

endpackage

/* sv/ise_cell.sv */
// ----------------------------------------------------------------------------
// Insertion sort cell
// Holds one value of the sorted run; shifts up on insert, down on drain.
// ----------------------------------------------------------------------------
module ise_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                ins_en_i,
  input  logic signed [ise_pkg::DataWidth-1:0] ins_value_i,
  input  logic                                shift_en_i,
  input  ise_pkg::cell_link_t                 lo_i,
  input  ise_pkg::cell_link_t                 hi_i,
  output ise_pkg::cell_link_t                 link_o
);
  import ise_pkg::*;

  logic                        valid_q, valid_d;
  logic signed [DataWidth-1:0] value_q, value_d;
  logic                        gt;

  // An empty cell counts as greater, so empties stay above the run.
  // Equal values are not greater, which keeps arrival order among ties.
  assign gt = !valid_q || (value_q > ins_value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ins_en_i) begin
      if (gt) begin
        value_d = lo_i.gt ? lo_i.value : ins_value_i;
        valid_d = valid_q | lo_i.valid;
      end
    end else if (shift_en_i) begin
      value_d = hi_i.value;
      valid_d = hi_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o = '{valid: valid_q, gt: gt, value: value_q};

endmodule

/* sv/insertion_sort_engine_top.sv */
// An insert beat is registered into the cell chain; a beat that flushes
// (last_in set, or the chain becomes full) shows its first result on the
// following cycle. Throughput: one insert per cycle while not draining; a
// run of n values drains at one result per cycle while out_stall_i is low,
// set by the single downward shift of the chain, input stalled.
// Reset empties every cell and clears the drain flag; cell values are unreset.
// ----------------------------------------------------------------------------
// Insertion sort engine
// Systolic chain of cells that keeps values in ascending signed order and
// streams the sorted run out smallest first.
// ----------------------------------------------------------------------------
module insertion_sort_engine_top #(
  parameter int unsigned MAX_ELEMENTS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ise_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ise_pkg::out_beat_t out_beat_o
);
  import ise_pkg::*;

  cell_link_t              links [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] valid_vec;
  logic                    draining_q, draining_d;
  logic                    in_fire, out_fire, flush;

  assign in_stall_o = draining_q;
  assign in_fire    = in_valid_i && !draining_q;
  assign out_valid_o = draining_q && valid_vec[0];
  assign out_fire   = out_valid_o && !out_stall_i;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    cell_link_t lo, hi;
    if (i == 0) begin : g_lo_head
      assign lo = HeadLink;
    end else begin : g_lo_mid
      assign lo = links[i-1];
    end
    if (i == MAX_ELEMENTS - 1) begin : g_hi_tail
      assign hi = TailLink;
    end else begin : g_hi_mid
      assign hi = links[i+1];
    end

    ise_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ins_en_i    (in_fire),
      .ins_value_i (in_beat_i.sample_value),
      .shift_en_i  (out_fire),
      .lo_i        (lo),
      .hi_i        (hi),
      .link_o      (links[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // The beat that occupies the top cell fills the chain and flushes it too.
  assign flush = in_beat_i.last_in || valid_vec[MAX_ELEMENTS-2];

  always_comb begin
    draining_d = draining_q;
    if (in_fire && flush) begin
      draining_d = 1'b1;
    end else if (out_fire && !valid_vec[1]) begin
      draining_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
    end else begin
      draining_q <= draining_d;
    end
  end

  assign out_beat_o = '{sorted_value: links[0].value, last_out: !valid_vec[1]};

`ifndef NO_ASSERTIONS
  // Occupied cells always form one contiguous run from the bottom.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec[MAX_ELEMENTS-1:1] & ~valid_vec[MAX_ELEMENTS-2:0]) == '0)
    else $error("occupied cells are not contiguous");

  // While draining there is always a value at the bottom cell.
  a_drain_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> valid_vec[0])
    else $error("draining with an empty bottom cell");

  // An insert with last_in set presents its first result on the next cycle.
  a_flush_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_beat_i.last_in) |=> out_valid_o)
    else $error("flush did not start the output run");

  // Taking the final result leaves the chain empty and ready for input.
  a_run_ends_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_beat_o.last_out) |=> (!draining_q && valid_vec == '0))
    else $error("chain not empty after the last result");
`endif

endmodule
